FILE: design/positional_list_engine_defines.svh
// Assertion macros used by the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTH

// ante |-> cons, sampled on i_clk, off during reset
`define PLE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// ante |=> cons, sampled on i_clk, off during reset
`define PLE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// invariant on every clock
`define PLE_ASSERT_ALW(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("invariant failed");

`else

`define PLE_ASSERT_IMP(label, ante, cons)
`define PLE_ASSERT_NXT(label, ante, cons)
`define PLE_ASSERT_ALW(label, expr)

`endif

`endif

FILE: design/ple_pkg.sv
// Package: opcodes, status codes, state types and control structs of the list engine.
`timescale 1ns / 1ps

package ple_pkg;

    typedef enum logic [2:0] {
        OP_INS_HEAD = 3'd0,
        OP_INS_TAIL = 3'd1,
        OP_INS_POS  = 3'd2,
        OP_DEL_HEAD = 3'd3,
        OP_DEL_TAIL = 3'd4,
        OP_DEL_POS  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_DONE
    } t_top_state;

    typedef enum logic {
        E_IDLE,
        E_RUN
    } t_eng_state;

    typedef struct packed {
        logic start;
        logic ins;
    } t_store_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_store_sts;

endpackage

FILE: design/positional_list_engine.sv
// Top level: request decode, element count, result register and the element store.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_op, i_value, i_position
//  out     | o_out_valid | i_out_ready | o_removed_value, o_status, o_length
//
// One transaction at a time. Rejected requests and unused opcodes skip the store.
// Inserts and deletes run the store, which opens or closes the gap from the index to
// the end of the list: ple_store moves one entry per cycle through the single write port.
// The result is registered and becomes valid as the engine returns to idle.
// Reset empties the list at once; no clearing pass.
// A new transaction is taken while the previous result waits on o_out_ready.
`timescale 1ns / 1ps
`include "positional_list_engine_defines.svh"

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_removed_value,
    output logic [1:0]         o_status,
    output logic [4:0]         o_length
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > 8) ? CW : 8) + 1;

    t_top_state    r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_start;
    logic          r_ins, r_del_ok;
    logic [AW-1:0] r_idx, r_first;
    logic [CW-1:0] r_num;
    logic [31:0]   r_val;
    t_status       r_status;

    logic          r_out_valid;
    logic [31:0]   r_out_removed;
    t_status       r_out_status;
    logic [4:0]    r_out_length;

    logic          accept, load_out;
    logic          d_work, d_ins, d_del_ok;
    t_status       d_status;
    logic [AW-1:0] d_idx, d_first;
    logic [CW-1:0] d_num;
    logic [XW-1:0] pos_x, cnt_x;
    logic          full, empty;

    t_store_ctl    ctl;
    t_store_sts    sts;
    logic [31:0]   removed;

    assign pos_x = XW'(i_position);
    assign cnt_x = XW'(r_count);
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        d_work   = 1'b0;
        d_ins    = 1'b0;
        d_status = ST_OK;
        d_idx    = '0;
        case (i_op)
            OP_INS_HEAD: begin
                if (full) d_status = ST_FULL;
                else begin
                    d_work = 1'b1;
                    d_ins  = 1'b1;
                end
            end
            OP_INS_TAIL: begin
                if (full) d_status = ST_FULL;
                else begin
                    d_work = 1'b1;
                    d_ins  = 1'b1;
                    d_idx  = AW'(r_count);
                end
            end
            OP_INS_POS: begin
                if (full) d_status = ST_FULL;
                else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) d_status = ST_BADPOS;
                else begin
                    d_work = 1'b1;
                    d_ins  = 1'b1;
                    d_idx  = AW'(pos_x - XW'(1));
                end
            end
            OP_DEL_HEAD: begin
                if (empty) d_status = ST_EMPTY;
                else d_work = 1'b1;
            end
            OP_DEL_TAIL: begin
                if (empty) d_status = ST_EMPTY;
                else begin
                    d_work = 1'b1;
                    d_idx  = AW'(r_count - CW'(1));
                end
            end
            OP_DEL_POS: begin
                if (empty) d_status = ST_EMPTY;
                else if (pos_x == '0 || pos_x > cnt_x) d_status = ST_BADPOS;
                else begin
                    d_work = 1'b1;
                    d_idx  = AW'(pos_x - XW'(1));
                end
            end
            default: d_status = ST_OK;
        endcase
        d_num    = r_count - CW'(d_idx);
        d_first  = d_ins ? AW'(r_count - CW'(1)) : d_idx;
        d_del_ok = d_work && !d_ins;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            T_IDLE: if (accept)   n_state = d_work ? T_RUN : T_DONE;
            T_RUN:  if (sts.done) n_state = T_DONE;
            T_DONE: if (load_out) n_state = T_IDLE;
            default:              n_state = T_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == T_IDLE);
        load_out   = (r_state == T_DONE) && (!r_out_valid || i_out_ready);
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= accept && d_work;
            if (sts.done) begin
                r_count <= r_ins ? r_count + CW'(1) : r_count - CW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ins    <= d_ins;
            r_del_ok <= d_del_ok;
            r_idx    <= d_idx;
            r_first  <= d_first;
            r_num    <= d_num;
            r_val    <= i_value;
            r_status <= d_status;
        end
        if (load_out) begin
            r_out_removed <= r_del_ok ? removed : 32'd0;
            r_out_status  <= r_status;
            r_out_length  <= 5'(r_count);
        end
    end

    assign ctl.start = r_start;
    assign ctl.ins   = r_ins;

    ple_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_first   (r_first),
        .i_idx     (r_idx),
        .i_num     (r_num),
        .i_value   (r_val),
        .o_sts     (sts),
        .o_removed (removed)
    );

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = $signed(r_out_removed);
    assign o_status        = r_out_status;
    assign o_length        = r_out_length;

    `PLE_ASSERT_ALW(a_count_max, r_count <= CW'(CAPACITY))
    `PLE_ASSERT_IMP(a_start_idle, r_start, !sts.busy)
    `PLE_ASSERT_IMP(a_done_in_run, sts.done, r_state == T_RUN)
    `PLE_ASSERT_NXT(a_accept_leaves_idle, accept, r_state != T_IDLE)

endmodule

FILE: design/ple_store.sv
// Element memory with the shift sequencer that opens or closes a gap one entry per cycle.
`timescale 1ns / 1ps

module ple_store
    import ple_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_store_ctl                    i_ctl,
    input  logic [$clog2(CAPACITY)-1:0]   i_first,
    input  logic [$clog2(CAPACITY)-1:0]   i_idx,
    input  logic [$clog2(CAPACITY+1)-1:0] i_num,
    input  logic [31:0]                   i_value,
    output t_store_sts                    o_sts,
    output logic [31:0]                   o_removed
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0] mem [CAPACITY];

    t_eng_state    r_est, n_est;
    logic [CW-1:0] r_left;
    logic          r_pend;
    logic [AW-1:0] r_raddr, r_paddr, r_idx;
    logic          r_cap, r_first, r_ins;
    logic [31:0]   r_val, r_rdata, r_removed;

    logic          rd_en, shift_we, fin, val_we, we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;

    assign rd_en    = (r_est == E_RUN) && (r_left != '0);
    assign shift_we = (r_est == E_RUN) && r_pend && !r_cap;
    assign fin      = (r_est == E_RUN) && (r_left == '0) && !r_pend;
    assign val_we   = fin && r_ins;
    assign we       = shift_we || val_we;
    assign waddr    = val_we ? r_idx : (r_ins ? r_paddr + AW'(1) : r_paddr - AW'(1));
    assign wdata    = val_we ? r_val : r_rdata;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[r_raddr];
        end
    end

    always_comb begin
        n_est = r_est;
        case (r_est)
            E_IDLE: if (i_ctl.start) n_est = E_RUN;
            E_RUN:  if (fin)         n_est = E_IDLE;
            default:                 n_est = E_IDLE;
        endcase
    end

    always_comb begin
        o_sts.busy = (r_est != E_IDLE);
        o_sts.done = fin;
    end

    assign o_removed = r_removed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est  <= E_IDLE;
            r_left <= '0;
            r_pend <= 1'b0;
        end else begin
            r_est <= n_est;
            if (r_est == E_IDLE && i_ctl.start) begin
                r_left <= i_num;
                r_pend <= 1'b0;
            end else if (r_est == E_RUN) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_left <= r_left - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_est == E_IDLE && i_ctl.start) begin
            r_raddr <= i_first;
            r_idx   <= i_idx;
            r_ins   <= i_ctl.ins;
            r_first <= !i_ctl.ins;
            r_val   <= i_value;
        end else if (rd_en) begin
            r_paddr <= r_raddr;
            r_cap   <= r_first;
            r_first <= 1'b0;
            r_raddr <= r_ins ? r_raddr - AW'(1) : r_raddr + AW'(1);
        end
        // first read of a delete is the removed element
        if (r_est == E_RUN && r_pend && r_cap) begin
            r_removed <= r_rdata;
        end
    end

endmodule
